// File: src/rscalu_pkg.sv
`timescale 1ns / 1ps
package rscalu_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned OpW   = 3;

  localparam logic [OpW-1:0] OP_ADD = 3'd0;
  localparam logic [OpW-1:0] OP_SUB = 3'd1;
  localparam logic [OpW-1:0] OP_MUL = 3'd2;
  localparam logic [OpW-1:0] OP_DIV = 3'd3;
  localparam logic [OpW-1:0] OP_OR  = 3'd4;
  localparam logic [OpW-1:0] OP_AND = 3'd5;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // Each divide stage resolves two quotient bits.
  localparam int unsigned DivStages = ChanW / 2;

  // Register stages from the start strobe to the result strobe: operand capture,
  // product and divide setup, the divide stages and the output register.
  localparam int unsigned Latency = DivStages + 3;

  // Partial state of one channel's long division.
  typedef struct packed {
    logic [ChanW-1:0] rem;  // running remainder, below the divisor
    logic [ChanW-1:0] num;  // numerator bits not yet brought down
    logic [ChanW-1:0] quo;  // quotient bits found so far
    logic [ChanW-1:0] dvs;  // divisor
  } div_t;

endpackage

// File: src/rgba8_saturating_channel_alu_core.sv
`timescale 1ns / 1ps
// Channel-wise RGBA8 arithmetic: add and subtract saturate, multiply gives
// a*b/255 and divide gives min(255, 255*a/b), with 255 for a zero divisor.
// The block accepts a new word every cycle (busy_o stays low) and returns each
// result on done_o, in order, after the lane's register stages. Their depth
// is set by the divide, whose eight quotient bits are resolved two per
// stage. Results are shown for one cycle only and must be taken then.
module rgba8_saturating_channel_alu_core
  import rscalu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [ChanW-1:0] lhs_red_i,
  input  logic [ChanW-1:0] lhs_green_i,
  input  logic [ChanW-1:0] lhs_blue_i,
  input  logic [ChanW-1:0] lhs_alpha_i,
  input  logic [ChanW-1:0] rhs_red_i,
  input  logic [ChanW-1:0] rhs_green_i,
  input  logic [ChanW-1:0] rhs_blue_i,
  input  logic [ChanW-1:0] rhs_alpha_i,
  output logic             done_o,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o,
  output logic [ChanW-1:0] out_alpha_o
);

  logic [Latency-1:0] vld_d;
  logic [Latency-1:0] vld_q;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[Latency-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[Latency-1];

  rscalu_lane u_lane_red (
    .clk_i (clk_i),
    .op_i  (op_i),
    .a_i   (lhs_red_i),
    .b_i   (rhs_red_i),
    .out_o (out_red_o)
  );

  rscalu_lane u_lane_green (
    .clk_i (clk_i),
    .op_i  (op_i),
    .a_i   (lhs_green_i),
    .b_i   (rhs_green_i),
    .out_o (out_green_o)
  );

  rscalu_lane u_lane_blue (
    .clk_i (clk_i),
    .op_i  (op_i),
    .a_i   (lhs_blue_i),
    .b_i   (rhs_blue_i),
    .out_o (out_blue_o)
  );

  rscalu_lane u_lane_alpha (
    .clk_i (clk_i),
    .op_i  (op_i),
    .a_i   (lhs_alpha_i),
    .b_i   (rhs_alpha_i),
    .out_o (out_alpha_o)
  );

endmodule

// File: src/rscalu_div_stage.sv
`timescale 1ns / 1ps
module rscalu_div_stage
  import rscalu_pkg::*;
(
  input  logic clk_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t       div_d;
  div_t       div_q;
  logic [8:0] r0;
  logic [8:0] d0;
  logic [7:0] rem0;
  logic       b0;
  logic [8:0] r1;
  logic [8:0] d1;
  logic [7:0] rem1;
  logic       b1;

  // Two restoring division steps per stage.
  always_comb begin
    r0   = {div_i.rem, div_i.num[7]};
    d0   = r0 - {1'b0, div_i.dvs};
    b0   = (r0 >= {1'b0, div_i.dvs});
    rem0 = b0 ? d0[7:0] : r0[7:0];

    r1   = {rem0, div_i.num[6]};
    d1   = r1 - {1'b0, div_i.dvs};
    b1   = (r1 >= {1'b0, div_i.dvs});
    rem1 = b1 ? d1[7:0] : r1[7:0];

    div_d.rem = rem1;
    div_d.num = {div_i.num[5:0], 2'b00};
    div_d.quo = {div_i.quo[5:0], b0, b1};
    div_d.dvs = div_i.dvs;
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

// File: src/rscalu_lane.sv
`timescale 1ns / 1ps
module rscalu_lane
  import rscalu_pkg::*;
(
  input  logic             clk_i,
  input  logic [OpW-1:0]   op_i,
  input  logic [ChanW-1:0] a_i,
  input  logic [ChanW-1:0] b_i,
  output logic [ChanW-1:0] out_o
);

  // Stage 1: operand capture.
  logic [OpW-1:0]   op1_q;
  logic [ChanW-1:0] a1_q;
  logic [ChanW-1:0] b1_q;

  always_ff @(posedge clk_i) begin
    op1_q <= op_i;
    a1_q  <= a_i;
    b1_q  <= b_i;
  end

  // Stage 2: simple operations, product, division setup.
  logic [ChanW:0]     sum1;
  logic [ChanW-1:0]   simple1;
  logic [2*ChanW-1:0] num1;
  div_t               div1;

  logic [OpW-1:0]     op2_q;
  logic [ChanW-1:0]   simple2_q;
  logic [2*ChanW-1:0] prod2_q;
  logic               sat2_q;
  div_t               div2_q;

  always_comb begin
    sum1 = {1'b0, a1_q} + {1'b0, b1_q};
    case (op1_q)
      OP_ADD:  simple1 = sum1[ChanW] ? ChanMax : sum1[ChanW-1:0];
      OP_SUB:  simple1 = (a1_q >= b1_q) ? (a1_q - b1_q) : '0;
      OP_OR:   simple1 = a1_q | b1_q;
      OP_AND:  simple1 = a1_q & b1_q;
      default: simple1 = a1_q;
    endcase
    num1     = {a1_q, {ChanW{1'b0}}} - {{ChanW{1'b0}}, a1_q};
    div1.rem = num1[2*ChanW-1:ChanW];
    div1.num = num1[ChanW-1:0];
    div1.quo = '0;
    div1.dvs = b1_q;
  end

  always_ff @(posedge clk_i) begin
    op2_q     <= op1_q;
    simple2_q <= simple1;
    prod2_q   <= a1_q * b1_q;
    // a >= b covers a zero divisor as well; both give full scale.
    sat2_q    <= (a1_q >= b1_q);
    div2_q    <= div1;
  end

  // Stage 3: product divided by 255, exact for products of two channel values.
  logic [2*ChanW:0] mq2;
  logic [ChanW-1:0] simple2;

  always_comb begin
    mq2 = {1'b0, prod2_q} + {{(ChanW+1){1'b0}}, prod2_q[2*ChanW-1:ChanW]} + 17'd1;
    simple2 = (op2_q == OP_MUL) ? mq2[2*ChanW-1:ChanW] : simple2_q;
  end

  logic [OpW-1:0]   op_q     [DivStages];
  logic [ChanW-1:0] simple_q [DivStages];
  logic             sat_q    [DivStages];
  div_t             div_w    [DivStages+1];

  assign div_w[0] = div2_q;

  always_ff @(posedge clk_i) begin
    op_q[0]     <= op2_q;
    simple_q[0] <= simple2;
    sat_q[0]    <= sat2_q;
    for (int i = 1; i < DivStages; i++) begin
      op_q[i]     <= op_q[i-1];
      simple_q[i] <= simple_q[i-1];
      sat_q[i]    <= sat_q[i-1];
    end
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    rscalu_div_stage u_div_stage (
      .clk_i (clk_i),
      .div_i (div_w[g]),
      .div_o (div_w[g+1])
    );
  end

  // Final selection into the output register.
  logic [ChanW-1:0] out_d;
  logic [ChanW-1:0] out_q;

  always_comb begin
    if (op_q[DivStages-1] == OP_DIV) begin
      out_d = sat_q[DivStages-1] ? ChanMax : div_w[DivStages].quo;
    end else begin
      out_d = simple_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule
